// ===== rtl/core/keyed_challenge_auth_card_defines.svh =====
// Assertion macros included by the datapath and the controller.
`ifndef KEYED_CHALLENGE_AUTH_CARD_DEFINES_SVH
`define KEYED_CHALLENGE_AUTH_CARD_DEFINES_SVH
// Antecedent implies consequent in the same cycle.
`define KCA_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define KCA_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== rtl/core/kca_pkg.sv =====
`default_nettype none
package kca_pkg;
    typedef enum logic [2:0] {
        KIND_TICK = 3'd0, KIND_INIT = 3'd1, KIND_READ = 3'd2, KIND_WRITE = 3'd3,
        KIND_XFORM = 3'd4, KIND_DWRITE = 3'd5, KIND_DREAD = 3'd6, KIND_UNKNOWN = 3'd7
    } kind_t;

    localparam logic CFG_KEY_SEED = 1'b0;
    localparam logic CFG_RELOAD = 1'b1;

    // Round modes of the datapath.
    typedef enum logic [1:0] {
        RM_FWD = 2'd0, RM_READ = 2'd1, RM_WRITE = 2'd2
    } round_mode_t;

    // Load operations issued by the controller.
    typedef enum logic [2:0] {
        LD_NONE = 3'd0, LD_INIT = 3'd1, LD_READ = 3'd2, LD_WRITE = 3'd3,
        LD_XFORM = 3'd4, LD_FINISH = 3'd5, LD_TICK = 3'd6, LD_DIRECT = 3'd7
    } load_op_t;

    // The capture bit marks the cycle in which an input word is accepted.
    typedef struct packed {
        load_op_t    load_op;
        round_mode_t mode;
        logic        round_en;
        logic        capture;
    } dp_cmd_t;

    typedef struct packed {
        logic direct_hit;
    } dp_status_t;

    localparam logic [39:0] MASK_A = 40'h33fbc752c9;
    localparam logic [39:0] MASK_B = 40'h2991a7f16b;
    localparam logic [47:0] MASK_C = 48'h8e65e1a37433;
    localparam logic [47:0] MASK_D = 48'h1de9433fb829;
    localparam logic [7:0] FWD_MUL = 8'h25;
    localparam logic [7:0] FWD_ADD = 8'h05;
    localparam logic [7:0] WR_MUL = 8'hAD;
    localparam logic [7:0] WR_ADD = 8'h9F;
    localparam logic [7:0] WR_X5 = 8'h8E;
    localparam logic [7:0] WR_X4 = 8'h65;
    localparam logic [7:0] WR_Y5 = 8'h1D;
    localparam logic [7:0] KEY_BASE = 8'h40;
    localparam logic [7:0] DIRECT_LO = 8'h20;
endpackage
`default_nettype wire

// ===== rtl/core/kca_if.sv =====
`default_nettype none
interface kca_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  address;
    logic [31:0] payload;
    logic        answered;
    modport source (output valid, kind, address, payload, answered, input ready);
    modport sink (input valid, kind, address, payload, answered, output ready);
endinterface

interface kca_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] reply_data;
    logic [2:0]  reply_bytes;
    modport source (output valid, reply_data, reply_bytes, input ready);
    modport sink (input valid, reply_data, reply_bytes, output ready);
endinterface

interface kca_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [55:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/keyed_challenge_auth_card.sv =====
// Channel   Dir  Payload
// in_ch     in   kind, address, payload, answered
// out_ch    out  reply_data, reply_bytes
// cfg_ch    in   index, data (key_seed, reload_enable)
// Init and transform run a load step, ROUND_COUNT rounds, a finish step and an output step.
// Read first passes the direct state for the registered store read; a direct command passes
// that state and, when it replies, the output state. One shared round unit acts on the cipher
// register. After reset the store is cleared one entry a cycle, all STORE_DEPTH entries, before
// items are taken. A stalled result holds the block until it is taken; configuration is always ready.
`default_nettype none
module keyed_challenge_auth_card #(
    parameter int ROUND_COUNT = 50,
    parameter int STORE_DEPTH = 64
) (
    input wire logic clk,
    input wire logic rst_n,
    kca_in_if.sink   in_ch,
    kca_out_if.source out_ch,
    kca_cfg_if.sink  cfg_ch
);
    logic [55:0] key_seed_reg;
    logic        reload_reg;
    kca_pkg::dp_cmd_t cmd;
    kca_pkg::dp_status_t status;
    logic clr_done_reg;
    logic [6:0] clr_cnt_reg;

    // Configuration registers accept a word in every cycle.
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_seed_reg <= '0;
            reload_reg <= 1'b1;
        end
        else if (cfg_ch.valid)
        begin
            if (cfg_ch.index == kca_pkg::CFG_KEY_SEED)
            begin
                key_seed_reg <= cfg_ch.data;
            end
            else
            begin
                reload_reg <= cfg_ch.data[0];
            end
        end
    end

    // Mirrors the datapath clearing sweep so no item enters during it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (!clr_done_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == 7'(STORE_DEPTH - 1))
            begin
                clr_done_reg <= 1'b1;
            end
        end
    end

    kca_ctrl #(.ROUND_COUNT(ROUND_COUNT)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .kind(in_ch.kind), .answered(in_ch.answered), .status(status), .cmd(cmd),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .clr_done(clr_done_reg)
    );

    kca_datapath #(.STORE_DEPTH(STORE_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .kind(in_ch.kind), .address(in_ch.address),
        .payload(in_ch.payload), .answered(in_ch.answered), .key_seed(key_seed_reg),
        .reload_enable(reload_reg), .status(status), .reply_data(out_ch.reply_data),
        .reply_bytes(out_ch.reply_bytes)
    );
endmodule
`default_nettype wire

// ===== rtl/core/kca_datapath.sv =====
`default_nettype none
`include "keyed_challenge_auth_card_defines.svh"
module kca_datapath #(
    parameter int STORE_DEPTH = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire kca_pkg::dp_cmd_t cmd,
    input  wire logic [2:0]       kind,
    input  wire logic [7:0]       address,
    input  wire logic [31:0]      payload,
    input  wire logic             answered,
    input  wire logic [55:0]      key_seed,
    input  wire logic             reload_enable,
    output kca_pkg::dp_status_t   status,
    output logic [47:0]           reply_data,
    output logic [2:0]            reply_bytes
);
    localparam int AW = $clog2(STORE_DEPTH);

    logic [87:0] st_reg, st_next;
    logic [31:0] chal_reg, chal_next;
    logic [47:0] rd_reg, rd_next;
    logic [2:0]  rb_reg, rb_next;
    logic        clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;
    logic [7:0]  mem [STORE_DEPTH];
    logic [7:0]  mem_q_reg;
    logic [2:0]  kind_reg;
    logic [7:0]  addr_reg;
    logic [7:0]  wval_reg;
    logic        we;
    logic [AW-1:0] waddr;
    logic [7:0]  wdata;
    logic [7:0]  key_b;
    logic [7:0]  rd_byte;
    logic [87:0] t;
    logic [47:0] up;
    logic        in_direct;
    logic        in_direct_q;

    assign in_direct = (address >= kca_pkg::DIRECT_LO) && ({24'd0, address} < STORE_DEPTH);
    assign in_direct_q = (addr_reg >= kca_pkg::DIRECT_LO) && ({24'd0, addr_reg} < STORE_DEPTH);
    assign status.direct_hit = in_direct;

    // Fields that are needed after the accept cycle are held here.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            addr_reg <= address;
            wval_reg <= payload[7:0];
        end
    end

    // Store read is registered; it is issued in the accept cycle.
    always_ff @(posedge clk)
    begin
        mem_q_reg <= mem[address[AW-1:0]];
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(STORE_DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        key_b = 8'h00;
        if (addr_reg >= kca_pkg::KEY_BASE && addr_reg <= kca_pkg::KEY_BASE + 8'd6)
        begin
            key_b = key_seed[8*(6 - (addr_reg[2:0])) +: 8];
        end
        rd_byte = ({24'd0, addr_reg} < STORE_DEPTH) ? mem_q_reg : key_b;
    end

    always_comb
    begin
        st_next = st_reg;
        chal_next = chal_reg;
        rd_next = rd_reg;
        rb_next = rb_reg;
        we = 1'b0;
        waddr = '0;
        wdata = 8'h00;
        t = st_reg;
        up = '0;
        if (clr_busy_reg)
        begin
            we = 1'b1;
            waddr = clr_addr_reg;
        end
        unique case (cmd.load_op)
            kca_pkg::LD_TICK:
            begin
                chal_next[31:24] = chal_reg[31:24] + 8'd1;
                chal_next[23:16] = chal_reg[23:16] + {7'd0, chal_reg[31:24] == 8'hFF};
                chal_next[15:8] = chal_reg[15:8] - 8'd1;
                chal_next[7:0] = chal_reg[7:0] + {7'd0, chal_reg[15:8] == 8'h00};
            end
            kca_pkg::LD_INIT:
            begin
                t[55:0] = key_seed;
                t[47:0] = t[47:0] ^ kca_pkg::MASK_D;
                st_next = t;
            end
            kca_pkg::LD_XFORM:
            begin
                t[87:56] = payload;
                if (reload_enable)
                begin
                    t[55:0] = key_seed;
                end
                t[87:48] = t[87:48] ^ kca_pkg::MASK_B;
                t[47:0] = t[47:0] ^ kca_pkg::MASK_D;
                st_next = t;
            end
            kca_pkg::LD_READ:
            begin
                t[55:48] = rd_byte;
                t[87:48] = t[87:48] ^ kca_pkg::MASK_B;
                st_next = t;
            end
            kca_pkg::LD_WRITE:
            begin
                rd_next = {16'd0, chal_reg};
                rb_next = 3'd4;
                if (answered)
                begin
                    t[55:32] = payload[23:0];
                    t[87:48] = t[87:48] ^ kca_pkg::MASK_A;
                    t[47:40] = t[47:40] ^ kca_pkg::WR_X5;
                    t[39:32] = t[39:32] ^ kca_pkg::WR_X4;
                    st_next = t;
                end
            end
            kca_pkg::LD_DIRECT:
            begin
                if (kind_reg == kca_pkg::KIND_DWRITE && in_direct_q)
                begin
                    we = 1'b1;
                    waddr = addr_reg[AW-1:0];
                    wdata = wval_reg;
                end
                rd_next = {40'd0, mem_q_reg};
                rb_next = 3'd1;
            end
            kca_pkg::LD_FINISH:
            begin
                unique case (cmd.mode)
                    kca_pkg::RM_READ:
                    begin
                        // Byte 6 is sent first, byte 10 last.
                        t[87:48] = t[87:48] ^ kca_pkg::MASK_A;
                        rd_next = {8'd0, t[55:48], t[63:56], t[71:64], t[79:72], t[87:80]};
                        rb_next = 3'd5;
                    end
                    kca_pkg::RM_WRITE:
                    begin
                        t[87:48] = t[87:48] ^ kca_pkg::MASK_B;
                        t[47:40] = t[47:40] ^ kca_pkg::WR_Y5;
                        if (t[87:56] == chal_reg && {24'd0, t[55:48]} < STORE_DEPTH)
                        begin
                            we = 1'b1;
                            waddr = t[48 +: AW];
                            wdata = t[47:40];
                        end
                    end
                    default:
                    begin
                        // Byte 5 is sent first, byte 0 last.
                        t[87:48] = t[87:48] ^ kca_pkg::MASK_A;
                        t[47:0] = t[47:0] ^ kca_pkg::MASK_C;
                        rd_next = t[47:0];
                        rb_next = 3'd6;
                    end
                endcase
                st_next = t;
            end
            default:
            begin
                if (cmd.round_en)
                begin
                    unique case (cmd.mode)
                        kca_pkg::RM_READ:
                        begin
                            t[87:48] = {st_reg[84:48], st_reg[87:85]};
                        end
                        kca_pkg::RM_WRITE:
                        begin
                            up = {st_reg[42:40], st_reg[87:43]};
                            for (int i = 0; i < 6; i++)
                            begin
                                up[8*i +: 8] = 8'(up[8*i +: 8] * kca_pkg::WR_MUL)
                                    + kca_pkg::WR_ADD;
                            end
                            t[87:40] = up;
                        end
                        default:
                        begin
                            for (int i = 0; i < 6; i++)
                            begin
                                t[8*i +: 8] = 8'(st_reg[8*i +: 8] * kca_pkg::FWD_MUL)
                                    + kca_pkg::FWD_ADD;
                            end
                            t = {t[84:0], t[87:85]};
                        end
                    endcase
                    st_next = t;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
            chal_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            chal_reg <= chal_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= rd_next;
        rb_reg <= rb_next;
    end

    assign reply_data = rd_reg;
    assign reply_bytes = rb_reg;
endmodule
`default_nettype wire

// ===== rtl/core/kca_ctrl.sv =====
`default_nettype none
`include "keyed_challenge_auth_card_defines.svh"
module kca_ctrl #(
    parameter int ROUND_COUNT = 50
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         kind,
    input  wire logic               answered,
    input  wire kca_pkg::dp_status_t status,
    output kca_pkg::dp_cmd_t        cmd,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire logic               clr_done
);
    localparam int CW = $clog2(ROUND_COUNT + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_DIRECT = 5'b00010, S_ROUND = 5'b00100,
        S_FINISH = 5'b01000, S_OUT = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    kca_pkg::round_mode_t mode_reg, mode_next;
    logic emit_reg, emit_next;
    logic acc;
    kca_pkg::kind_t k;

    assign k = kca_pkg::kind_t'(kind);
    assign in_ready = (state_reg == S_IDLE) && clr_done;
    assign acc = in_valid && in_ready;
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        mode_next = mode_reg;
        emit_next = emit_reg;
        cmd.load_op = kca_pkg::LD_NONE;
        cmd.mode = mode_reg;
        cmd.round_en = 1'b0;
        cmd.capture = acc;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    cnt_next = CW'(ROUND_COUNT);
                    unique case (k)
                        kca_pkg::KIND_TICK: cmd.load_op = kca_pkg::LD_TICK;
                        kca_pkg::KIND_INIT:
                        begin
                            cmd.load_op = kca_pkg::LD_INIT;
                            mode_next = kca_pkg::RM_FWD;
                            state_next = S_ROUND;
                        end
                        kca_pkg::KIND_XFORM:
                        begin
                            cmd.load_op = kca_pkg::LD_XFORM;
                            mode_next = kca_pkg::RM_FWD;
                            state_next = S_ROUND;
                        end
                        kca_pkg::KIND_WRITE:
                        begin
                            cmd.load_op = kca_pkg::LD_WRITE;
                            mode_next = kca_pkg::RM_WRITE;
                            state_next = answered ? S_ROUND : S_OUT;
                            emit_next = 1'b1;
                        end
                        kca_pkg::KIND_READ, kca_pkg::KIND_DWRITE, kca_pkg::KIND_DREAD:
                        begin
                            emit_next = (k == kca_pkg::KIND_DREAD) && status.direct_hit;
                            mode_next = (k == kca_pkg::KIND_READ) ? kca_pkg::RM_READ
                                                                  : kca_pkg::RM_FWD;
                            state_next = S_DIRECT;
                        end
                        default: cmd.load_op = kca_pkg::LD_NONE;
                    endcase
                end
            end
            S_DIRECT:
            begin
                // Store data is now registered; the datapath holds the address.
                if (mode_reg == kca_pkg::RM_READ)
                begin
                    cmd.load_op = kca_pkg::LD_READ;
                    state_next = S_ROUND;
                end
                else
                begin
                    cmd.load_op = kca_pkg::LD_DIRECT;
                    state_next = emit_reg ? S_OUT : S_IDLE;
                end
            end
            S_ROUND:
            begin
                cmd.round_en = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.load_op = kca_pkg::LD_FINISH;
                emit_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            mode_reg <= kca_pkg::RM_FWD;
            emit_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            mode_reg <= mode_next;
            emit_reg <= emit_next;
        end
    end

    `KCA_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_reg), "state not one-hot")
    `KCA_ASSERT_NEXT(a_round_end, clk, rst_n, state_reg == S_ROUND && cnt_reg == CW'(1), state_reg == S_FINISH, "round count overrun")
    `KCA_ASSERT_IMP(a_no_acc_busy, clk, rst_n, state_reg != S_IDLE, !in_ready, "ready while busy")
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import kca_pkg::*;

    // Number of cipher rounds the block runs for init, transform, read and answered write.
    localparam int ROUNDS = 50;
    // Cycles without any accepted word before the run is declared hung.
    localparam int STALL_LIMIT = 20000;
    // Length of the long receiver hold-off that fills the block.
    localparam int HOLD_CYCLES = 600;
    // Quiet cycles after the last result: longer than one keyed command.
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  address;
        logic [31:0] payload;
        logic        answered;
    } card_cmd_t;

    typedef struct {
        logic [47:0] data;
        logic [2:0]  nbytes;
    } card_reply_t;

    // The scoreboard carries its own copy of the card state. Every accepted
    // command word updates it and queues any reply the card should send.
    class card_scoreboard;
        bit [55:0]   key_seed;
        bit          reload;
        bit [87:0]   cipher;
        bit [31:0]   challenge;
        bit [7:0]    store [64];
        card_reply_t replies_q [$];
        int          errors;

        function new();
            key_seed = '0;
            reload = 1'b1;
            cipher = '0;
            challenge = '0;
            foreach (store[i]) store[i] = 8'h00;
            errors = 0;
        endfunction

        function void set_cfg(logic idx, logic [55:0] d);
            if (idx == CFG_KEY_SEED) key_seed = d;
            else reload = d[0];
        endfunction

        // Forward cipher: affine step on the low six bytes, then the whole
        // 88-bit state rotates left by three.
        function bit [47:0] forward_cipher();
            cipher[47:0] ^= MASK_D;
            for (int n = 0; n < ROUNDS; n++)
            begin
                for (int i = 0; i < 6; i++)
                    cipher[8*i +: 8] = cipher[8*i +: 8] * FWD_MUL + FWD_ADD;
                cipher = {cipher[84:0], cipher[87:85]};
            end
            cipher[87:48] ^= MASK_A;
            cipher[47:0] ^= MASK_C;
            return cipher[47:0];
        endfunction

        function void note_input(card_cmd_t c);
            card_reply_t r;
            bit [7:0] c0, c1, c2, c3, v;
            bit [39:0] top;
            bit [47:0] mid;
            bit has_reply;
            has_reply = 1'b0;
            r.data = '0;
            r.nbytes = '0;
            case (c.kind)
                KIND_TICK:
                begin
                    {c0, c1, c2, c3} = challenge;
                    c0++;
                    if (c0 == 8'h00) c1++;
                    c2--;
                    if (c2 == 8'hFF) c3++;
                    challenge = {c0, c1, c2, c3};
                end
                KIND_INIT:
                begin
                    cipher[55:0] = key_seed;
                    r.data = forward_cipher();
                    r.nbytes = 3'd6;
                    has_reply = 1'b1;
                end
                KIND_READ:
                begin
                    if (c.address < 8'd64) v = store[c.address[5:0]];
                    else if (c.address <= KEY_BASE + 8'd6)
                        v = key_seed[8*(6 - (c.address - KEY_BASE)) +: 8];
                    else v = 8'h00;
                    cipher[55:48] = v;
                    cipher[87:48] ^= MASK_B;
                    top = cipher[87:48];
                    for (int n = 0; n < ROUNDS; n++)
                        top = {top[36:0], top[39:37]};
                    cipher[87:48] = top ^ MASK_A;
                    // Byte 6 is sent first, byte 10 last.
                    r.data = {8'h00, cipher[55:48], cipher[63:56], cipher[71:64],
                              cipher[79:72], cipher[87:80]};
                    r.nbytes = 3'd5;
                    has_reply = 1'b1;
                end
                KIND_WRITE:
                begin
                    r.data = {16'h0000, challenge};
                    r.nbytes = 3'd4;
                    has_reply = 1'b1;
                    if (c.answered)
                    begin
                        cipher[55:32] = c.payload[23:0];
                        cipher[87:48] ^= MASK_A;
                        cipher[47:40] ^= WR_X5;
                        cipher[39:32] ^= WR_X4;
                        mid = cipher[87:40];
                        for (int n = 0; n < ROUNDS; n++)
                        begin
                            mid = {mid[2:0], mid[47:3]};
                            for (int i = 0; i < 6; i++)
                                mid[8*i +: 8] = mid[8*i +: 8] * WR_MUL + WR_ADD;
                        end
                        cipher[87:40] = mid;
                        cipher[87:48] ^= MASK_B;
                        cipher[47:40] ^= WR_Y5;
                        // The store is only written when the decrypted
                        // challenge matches and the address is in range.
                        if (cipher[87:56] == challenge && cipher[55:48] < 8'd64)
                            store[cipher[53:48]] = cipher[47:40];
                    end
                end
                KIND_XFORM:
                begin
                    cipher[87:56] = c.payload;
                    if (reload) cipher[55:0] = key_seed;
                    cipher[87:48] ^= MASK_B;
                    r.data = forward_cipher();
                    r.nbytes = 3'd6;
                    has_reply = 1'b1;
                end
                KIND_DWRITE:
                    if (c.address >= DIRECT_LO && c.address < 8'd64)
                        store[c.address[5:0]] = c.payload[7:0];
                KIND_DREAD:
                    if (c.address >= DIRECT_LO && c.address < 8'd64)
                    begin
                        r.data = {40'h0, store[c.address[5:0]]};
                        r.nbytes = 3'd1;
                        has_reply = 1'b1;
                    end
                default: ;
            endcase
            if (has_reply) replies_q.push_back(r);
        endfunction

        function void check_reply(logic [47:0] d, logic [2:0] n);
            card_reply_t e;
            if (replies_q.size() == 0)
            begin
                $display("%0t: unexpected reply data=%h bytes=%0d", $time, d, n);
                errors++;
                return;
            end
            e = replies_q.pop_front();
            if (d !== e.data)
            begin
                $display("%0t: reply_data expected %h actual %h", $time, e.data, d);
                errors++;
            end
            if (n !== e.nbytes)
            begin
                $display("%0t: reply_bytes expected %0d actual %0d", $time, e.nbytes, n);
                errors++;
            end
        endfunction

        // Works the write decryption backwards from the wanted outcome. It
        // returns the upper 32 cipher bits the card must hold beforehand and
        // the payload that makes the check pass.
        function bit [31:0] plan_write(bit [5:0] addr, bit [7:0] val,
                                       output bit [31:0] pay);
            bit [47:0] mid;
            mid = {challenge, 2'b00, addr, val} ^ {MASK_B, WR_Y5};
            for (int n = 0; n < ROUNDS; n++)
            begin
                for (int i = 0; i < 6; i++)
                    mid[8*i +: 8] = (mid[8*i +: 8] - WR_ADD) * FWD_MUL;
                mid = {mid[44:0], mid[47:45]};
            end
            pay = {8'($urandom), mid[15:8] ^ MASK_A[7:0], mid[7:0] ^ WR_X5,
                   8'($urandom)};
            return mid[47:16] ^ MASK_A[39:8];
        endfunction

        // Finds the key seed and transform payload that leave the cipher
        // register at the given value after a transform with reload set.
        function void plan_transform(bit [87:0] target, output bit [55:0] k,
                                     output bit [31:0] pay);
            bit [87:0] s;
            s = target;
            s[47:0] ^= MASK_C;
            s[87:48] ^= MASK_A;
            for (int n = 0; n < ROUNDS; n++)
            begin
                s = {s[2:0], s[87:3]};
                for (int i = 0; i < 6; i++)
                    s[8*i +: 8] = (s[8*i +: 8] - FWD_ADD) * WR_MUL;
            end
            s[47:0] ^= MASK_D;
            k = {s[55:48] ^ MASK_B[7:0], s[47:0]};
            pay = s[87:56] ^ MASK_B[39:8];
        endfunction
    endclass

    logic clk;
    logic rst_n;
    kca_in_if  in_ch ();
    kca_out_if out_ch ();
    kca_cfg_if cfg_ch ();

    keyed_challenge_auth_card u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    card_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;
    int stall_count;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: random back-pressure, plus one long hold-off on request so
    // that the card fills up and stops taking command words.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Every reply word that is taken is checked against the oldest
    // outstanding prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_reply(out_ch.reply_data, out_ch.reply_bytes);
    end

    // The watchdog ends the run if no word moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offers one command word. The valid line is left high after the word
    // is taken so that back-to-back words follow without dropping valid.
    task automatic send_cmd(card_cmd_t c);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(4, 1);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= c.kind;
        in_ch.address <= c.address;
        in_ch.payload <= c.payload;
        in_ch.answered <= c.answered;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_input(c);
    endtask

    task automatic send_fields(kind_t k, logic [7:0] a, logic [31:0] p, logic ans);
        card_cmd_t c;
        c.kind = k;
        c.address = a;
        c.payload = p;
        c.answered = ans;
        send_cmd(c);
    endtask

    task automatic write_cfg(logic idx, logic [55:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= d;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.set_cfg(idx, d);
    endtask

    // Waits for every predicted reply, then lets a command that sends no
    // reply finish before the card is reconfigured.
    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        while (sb.replies_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Sets up the cipher register through a transform so that the following
    // answered write passes the challenge check and writes the store, then reads it back.
    task automatic store_by_challenge();
        bit [5:0]  addr;
        bit [7:0]  val;
        bit [31:0] wpay, tpay, upper;
        bit [55:0] k;
        addr = 6'($urandom);
        val = 8'($urandom);
        upper = sb.plan_write(addr, val, wpay);
        sb.plan_transform({upper, 24'($urandom), 32'($urandom)}, k, tpay);
        write_cfg(CFG_KEY_SEED, k);
        write_cfg(CFG_RELOAD, 56'd1);
        send_fields(KIND_XFORM, 8'h00, tpay, 1'b0);
        send_fields(KIND_WRITE, 8'h00, wpay, 1'b1);
        if (addr >= DIRECT_LO[5:0])
            send_fields(KIND_DREAD, {2'b00, addr}, 32'h0, 1'b0);
        else
            send_fields(KIND_READ, {2'b00, addr}, 32'h0, 1'b0);
    endtask

    function automatic card_cmd_t random_cmd();
        card_cmd_t c;
        int pick;
        pick = $urandom_range(99);
        if (pick < 20) c.kind = KIND_TICK;
        else if (pick < 30) c.kind = KIND_INIT;
        else if (pick < 45) c.kind = KIND_READ;
        else if (pick < 60) c.kind = KIND_WRITE;
        else if (pick < 70) c.kind = KIND_XFORM;
        else if (pick < 82) c.kind = KIND_DWRITE;
        else if (pick < 94) c.kind = KIND_DREAD;
        else c.kind = KIND_UNKNOWN;
        // Most addresses land on the store and the key bytes.
        if ($urandom_range(99) < 70) c.address = 8'($urandom_range(8'h4F));
        else c.address = 8'($urandom);
        pick = $urandom_range(19);
        if (pick == 0) c.payload = 32'h0;
        else if (pick == 1) c.payload = 32'hFFFF_FFFF;
        else c.payload = $urandom;
        c.answered = 1'($urandom);
        return c;
    endfunction

    initial
    begin
        bit [55:0] k;
        sb = new();
        hold_req = 1'b0;
        stall_count = 0;
        send_idle_pct = 20;
        recv_idle_pct = 55;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_TICK;
        in_ch.address = '0;
        in_ch.payload = '0;
        in_ch.answered = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_KEY_SEED;
        cfg_ch.data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words with the reset configuration: every command, the
        // store window edges, the key bytes and the zero region above them.
        send_fields(KIND_TICK, 8'h00, 32'h0, 1'b0);
        send_fields(KIND_INIT, 8'h00, 32'h0, 1'b0);
        send_fields(KIND_READ, 8'h00, 32'h0, 1'b0);
        send_fields(KIND_READ, 8'h3F, 32'h0, 1'b0);
        send_fields(KIND_READ, 8'h40, 32'h0, 1'b0);
        send_fields(KIND_READ, 8'h46, 32'h0, 1'b0);
        send_fields(KIND_READ, 8'h47, 32'h0, 1'b0);
        send_fields(KIND_READ, 8'hFF, 32'h0, 1'b0);
        send_fields(KIND_WRITE, 8'h00, 32'hFFFF_FFFF, 1'b0);
        send_fields(KIND_WRITE, 8'hFF, 32'h1234_5678, 1'b1);
        send_fields(KIND_XFORM, 8'h00, 32'h0, 1'b0);
        send_fields(KIND_XFORM, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        send_fields(KIND_DWRITE, 8'h1F, 32'h0000_00A5, 1'b0);
        send_fields(KIND_DWRITE, 8'h20, 32'hFFFF_FFFF, 1'b0);
        send_fields(KIND_DWRITE, 8'h3F, 32'h0000_0000, 1'b0);
        send_fields(KIND_DWRITE, 8'h40, 32'h0000_005A, 1'b0);
        send_fields(KIND_DREAD, 8'h1F, 32'h0, 1'b0);
        send_fields(KIND_DREAD, 8'h20, 32'h0, 1'b0);
        send_fields(KIND_DREAD, 8'h3F, 32'h0, 1'b0);
        send_fields(KIND_DREAD, 8'h40, 32'h0, 1'b0);
        send_fields(KIND_UNKNOWN, 8'hFF, 32'hFFFF_FFFF, 1'b1);

        // Three idling patterns; each runs blocks of random words under a
        // different configuration, each block opened by a write that passes
        // the challenge check.
        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle_pct = 55;
                recv_idle_pct = 20;
            end
            else if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int blk = 0; blk < 6; blk++)
            begin
                wait_quiet();
                store_by_challenge();
                wait_quiet();
                if (blk == 0) k = '0;
                else if (blk == 1) k = '1;
                else k = {24'($urandom), 32'($urandom)};
                write_cfg(CFG_KEY_SEED, k);
                write_cfg(CFG_RELOAD, (blk == 1) ? 56'd0 :
                          (blk == 0) ? 56'd1 : 56'($urandom_range(1)));
                if (phase == 0 && blk == 2) hold_req = 1'b1;
                for (int i = 0; i < 100; i++)
                    send_cmd(random_cmd());
            end
        end

        wait_quiet();
        if (sb.errors == 0 && sb.replies_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/kca_pkg.sv
rtl/core/kca_if.sv
rtl/core/kca_datapath.sv
rtl/core/kca_ctrl.sv
rtl/core/keyed_challenge_auth_card.sv
tb/testbench.sv
